FILE: hw/rtl/qvr_pkg.sv
// Shared definitions for the quaternion vector rotator: default widths,
// register index codes and the control bundle of a product-sum lane.
// No dependencies; every other file of the block uses this package.
package qvr_pkg;

   localparam int QVR_COORD_WIDTH    = 16;
   localparam int QVR_QUAT_FRAC_BITS = 14;

   // Quaternion registers are always 16 bits wide.
   localparam int QREG_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = QREG_WIDTH;

   // Each lane sums four signed products.
   localparam int LANE_TERMS = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_QUAT_X = 2'd0,
      CSR_QUAT_Y = 2'd1,
      CSR_QUAT_Z = 2'd2,
      CSR_QUAT_W = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } lane_ctl_type;

endpackage

FILE: hw/rtl/qvr_if.sv
// Valid/ready channel interfaces for the rotator: vector items in and
// rotated items out. Depends on qvr_pkg for the default coordinate width.
interface qvr_req_if #(parameter int COORD_WIDTH = qvr_pkg::QVR_COORD_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vec_x;
   logic signed [COORD_WIDTH-1:0] vec_y;
   logic signed [COORD_WIDTH-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_rsp_if #(parameter int COORD_WIDTH = qvr_pkg::QVR_COORD_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rot_x;
   logic signed [COORD_WIDTH-1:0] rot_y;
   logic signed [COORD_WIDTH-1:0] rot_z;
   logic                          clipped;

   modport source (output valid, output rot_x, output rot_y, output rot_z,
                   output clipped, input ready);
   modport sink (input valid, input rot_x, input rot_y, input rot_z,
                 input clipped, output ready);
endinterface

FILE: hw/rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotator: register file, pipeline
// control, seven product-sum lanes and the output stage.
// Depends on qvr_pkg, qvr_if, qvr_lane and qvr_merge.
//
//   channel   direction   handshake          payload
//   req_chan  in          valid/ready        vec_x, vec_y, vec_z
//   rsp_chan  out         valid/ready        rot_x, rot_y, rot_z, clipped
//   csr_*     in          csr_we only        csr_index, csr_wdata
//
// One item per cycle unless stalled; a result is offered once its item clears
// five registers (two multiply-add passes of two stages each, then the output
// register, the first loading at the accepting edge). Each stage
// moves on whenever the stage after it is empty or moving, so bubbles collapse
// and req_chan.ready falls only once every stage holds an item behind a stalled
// result. Reset empties the pipeline and loads the identity quaternion.
module quaternion_vector_rotate #(
   parameter int COORD_WIDTH    = qvr_pkg::QVR_COORD_WIDTH,
   parameter int QUAT_FRAC_BITS = qvr_pkg::QVR_QUAT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [qvr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qvr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   qvr_req_if.sink                             req_chan,
   qvr_rsp_if.source                           rsp_chan
);
   import qvr_pkg::*;

   localparam int T_WIDTH   = QREG_WIDTH + COORD_WIDTH + 2;
   localparam int R_WIDTH   = QREG_WIDTH + T_WIDTH + 2;
   localparam int OUT_SHIFT = 2 * QUAT_FRAC_BITS;
   localparam int STAGES    = 5;

   logic [QREG_WIDTH-1:0] quat_x_ff, quat_x_in;
   logic [QREG_WIDTH-1:0] quat_y_ff, quat_y_in;
   logic [QREG_WIDTH-1:0] quat_z_ff, quat_z_in;
   logic [QREG_WIDTH-1:0] quat_w_ff, quat_w_in;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] adv;

   lane_ctl_type ctl_first, ctl_second;

   logic [COORD_WIDTH-1:0] vx, vy, vz, vzero;
   logic [T_WIDTH-1:0]     t0, t1, t2, t3;
   logic [R_WIDTH-1:0]     r0, r1, r2;
   logic [2:0][COORD_WIDTH-1:0] rots;

   // Register file; the user must write it only while the block is idle, which the block does not enforce.
   always_comb begin
      quat_x_in = quat_x_ff;
      quat_y_in = quat_y_ff;
      quat_z_in = quat_z_ff;
      quat_w_in = quat_w_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUAT_X: quat_x_in = csr_wdata;
            CSR_QUAT_Y: quat_y_in = csr_wdata;
            CSR_QUAT_Z: quat_z_in = csr_wdata;
            CSR_QUAT_W: quat_w_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when the next stage takes its item.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_chan.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_chan.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
      ctl_first.prod_en  = adv[0];
      ctl_first.sum_en   = adv[1];
      ctl_second.prod_en = adv[2];
      ctl_second.sum_en  = adv[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         quat_w_ff <= QREG_WIDTH'(1) << QUAT_FRAC_BITS;
         valid_ff  <= '0;
      end else begin
         quat_x_ff <= quat_x_in;
         quat_y_ff <= quat_y_in;
         quat_z_ff <= quat_z_in;
         quat_w_ff <= quat_w_in;
         valid_ff  <= valid_in;
      end
   end

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = valid_ff[STAGES-1];

   assign vx    = req_chan.vec_x;
   assign vy    = req_chan.vec_y;
   assign vz    = req_chan.vec_z;
   assign vzero = '0;

   // First pass: t = q * (v, 0).
   qvr_lane #(.OPND_WIDTH(COORD_WIDTH), .SUB_MASK(4'b0100)) u_lane_t0 (
      .clock(clock), .ctl(ctl_first),
      .coef({quat_x_ff, quat_z_ff, quat_y_ff, quat_w_ff}),
      .opnd({vzero, vy, vz, vx}), .sum(t0));

   qvr_lane #(.OPND_WIDTH(COORD_WIDTH), .SUB_MASK(4'b0010)) u_lane_t1 (
      .clock(clock), .ctl(ctl_first),
      .coef({quat_y_ff, quat_z_ff, quat_x_ff, quat_w_ff}),
      .opnd({vzero, vx, vz, vy}), .sum(t1));

   qvr_lane #(.OPND_WIDTH(COORD_WIDTH), .SUB_MASK(4'b0100)) u_lane_t2 (
      .clock(clock), .ctl(ctl_first),
      .coef({quat_z_ff, quat_y_ff, quat_x_ff, quat_w_ff}),
      .opnd({vzero, vx, vy, vz}), .sum(t2));

   qvr_lane #(.OPND_WIDTH(COORD_WIDTH), .SUB_MASK(4'b0111)) u_lane_t3 (
      .clock(clock), .ctl(ctl_first),
      .coef({quat_w_ff, quat_z_ff, quat_y_ff, quat_x_ff}),
      .opnd({vzero, vz, vy, vx}), .sum(t3));

   // Second pass: r = t * conj(q); the conjugate's signs sit in SUB_MASK.
   qvr_lane #(.OPND_WIDTH(T_WIDTH), .SUB_MASK(4'b1100)) u_lane_r0 (
      .clock(clock), .ctl(ctl_second),
      .coef({quat_x_ff, quat_z_ff, quat_y_ff, quat_w_ff}),
      .opnd({t3, t1, t2, t0}), .sum(r0));

   qvr_lane #(.OPND_WIDTH(T_WIDTH), .SUB_MASK(4'b1100)) u_lane_r1 (
      .clock(clock), .ctl(ctl_second),
      .coef({quat_y_ff, quat_x_ff, quat_z_ff, quat_w_ff}),
      .opnd({t3, t2, t0, t1}), .sum(r1));

   qvr_lane #(.OPND_WIDTH(T_WIDTH), .SUB_MASK(4'b1100)) u_lane_r2 (
      .clock(clock), .ctl(ctl_second),
      .coef({quat_z_ff, quat_y_ff, quat_x_ff, quat_w_ff}),
      .opnd({t3, t0, t1, t2}), .sum(r2));

   qvr_merge #(
      .COORD_WIDTH(COORD_WIDTH),
      .SUM_WIDTH  (R_WIDTH),
      .OUT_SHIFT  (OUT_SHIFT)
   ) u_merge (
      .clock  (clock),
      .load_en(adv[STAGES-1]),
      .sums   ({r2, r1, r0}),
      .rots   (rots),
      .clipped(rsp_chan.clipped)
   );

   assign rsp_chan.rot_x = rots[0];
   assign rsp_chan.rot_y = rots[1];
   assign rsp_chan.rot_z = rots[2];

endmodule

FILE: hw/rtl/qvr_lane.sv
// One product-sum lane: four signed coefficient-by-operand products,
// registered, then added or subtracted into a registered sum. Uses qvr_pkg.
module qvr_lane #(
   parameter int               OPND_WIDTH = qvr_pkg::QVR_COORD_WIDTH,
   parameter logic [qvr_pkg::LANE_TERMS-1:0] SUB_MASK = '0,
   localparam int              SUM_WIDTH  = qvr_pkg::QREG_WIDTH + OPND_WIDTH + 2
) (
   input  logic                                                   clock,
   input  qvr_pkg::lane_ctl_type                                  ctl,
   input  logic [qvr_pkg::LANE_TERMS-1:0][qvr_pkg::QREG_WIDTH-1:0] coef,
   input  logic [qvr_pkg::LANE_TERMS-1:0][OPND_WIDTH-1:0]          opnd,
   output logic [SUM_WIDTH-1:0]                                   sum
);
   import qvr_pkg::*;

   localparam int PROD_WIDTH = QREG_WIDTH + OPND_WIDTH;

   logic signed [PROD_WIDTH-1:0] prod_in [LANE_TERMS];
   logic signed [PROD_WIDTH-1:0] prod_ff [LANE_TERMS];
   logic signed [SUM_WIDTH-1:0]  sum_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff;

   always_comb begin
      for (int i = 0; i < LANE_TERMS; i++) begin
         prod_in[i] = $signed(coef[i]) * $signed(opnd[i]);
      end
   end

   // Four terms of PROD_WIDTH bits fit in two extra bits of headroom.
   always_comb begin
      logic signed [SUM_WIDTH-1:0] term;
      sum_in = '0;
      for (int i = 0; i < LANE_TERMS; i++) begin
         term = {{2{prod_ff[i][PROD_WIDTH-1]}}, prod_ff[i]};
         if (SUB_MASK[i]) begin
            sum_in = sum_in - term;
         end else begin
            sum_in = sum_in + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

FILE: hw/rtl/qvr_merge.sv
// Output stage: rounds the three lane sums half up, saturates each to the
// coordinate width and merges the per-lane overflow into one flag.
// Uses qvr_pkg.
module qvr_merge #(
   parameter int COORD_WIDTH = qvr_pkg::QVR_COORD_WIDTH,
   parameter int SUM_WIDTH   = 52,
   parameter int OUT_SHIFT   = 2 * qvr_pkg::QVR_QUAT_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            load_en,
   input  logic [2:0][SUM_WIDTH-1:0]       sums,
   output logic [2:0][COORD_WIDTH-1:0]     rots,
   output logic                            clipped
);
   import qvr_pkg::*;

   localparam int RW = SUM_WIDTH + 1;
   localparam logic [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
   localparam logic signed [RW-1:0] MAX_V = {{(RW-COORD_WIDTH+1){1'b0}},
                                             {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_V = {{(RW-COORD_WIDTH+1){1'b1}},
                                             {(COORD_WIDTH-1){1'b0}}};

   logic [2:0][COORD_WIDTH-1:0] rot_in;
   logic [2:0][COORD_WIDTH-1:0] rot_ff;
   logic                        clip_in;
   logic                        clip_ff;

   always_comb begin
      logic [RW-1:0]        ext;
      logic signed [RW-1:0] rnd;
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ext = {sums[i][SUM_WIDTH-1], sums[i]};
         // Adding half and then flooring sends ties toward plus infinity.
         rnd = $signed(ext + HALF) >>> OUT_SHIFT;
         if (rnd > MAX_V) begin
            rot_in[i] = MAX_V[COORD_WIDTH-1:0];
            clip_in   = 1'b1;
         end else if (rnd < MIN_V) begin
            rot_in[i] = MIN_V[COORD_WIDTH-1:0];
            clip_in   = 1'b1;
         end else begin
            rot_in[i] = rnd[COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         rot_ff  <= rot_in;
         clip_ff <= clip_in;
      end
   end

   assign rots    = rot_ff;
   assign clipped = clip_ff;

endmodule
